/* design/itp_pkg.sv */
// itp_pkg: shared types, codes and sizes for the infix to postfix converter
// no dependencies; used by every module of the converter
package itp_pkg;

   localparam int STACK_DEPTH   = 16;
   localparam int OPERAND_WIDTH = 32;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   // operand field mask, all ones when the operand fills the field
   localparam logic [31:0] OPERAND_MASK =
      (OPERAND_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << OPERAND_WIDTH) - 64'd1);

   // token kinds
   localparam logic [2:0] TOK_OPERAND  = 3'd0;
   localparam logic [2:0] TOK_OPERATOR = 3'd1;
   localparam logic [2:0] TOK_LPAREN   = 3'd2;
   localparam logic [2:0] TOK_RPAREN   = 3'd3;
   localparam logic [2:0] TOK_END      = 3'd4;

   // operator codes, plus the stack marker for an open paren
   localparam logic [2:0] OP_POW      = 3'd0;
   localparam logic [2:0] OP_MUL      = 3'd1;
   localparam logic [2:0] OP_DIV      = 3'd2;
   localparam logic [2:0] OP_ADD      = 3'd3;
   localparam logic [2:0] OP_SUB      = 3'd4;
   localparam logic [2:0] LPAREN_CODE = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] operand;
      logic [2:0]  operator_code;
      logic [1:0]  error;
   } result_type;

   // sequencer to output stage
   typedef struct packed {
      logic       emit;
      logic       close;
      result_type result;
   } emit_type;

   function automatic logic [1:0] prec_of(input logic [2:0] op);
      logic [1:0] p;
      if (op == OP_POW) begin
         p = 2'd3;
      end else if (op <= OP_DIV) begin
         p = 2'd2;
      end else begin
         p = 2'd1;
      end
      return p;
   endfunction

endpackage

/* design/itp_stack.sv */
// itp_stack: operator stack storage, one write port and one registered read port
// depends on itp_pkg for depth and address width
module itp_stack (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [itp_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [2:0]                  wr_data,
   input  logic [itp_pkg::ADDR_W-1:0]  rd_addr,
   output logic [2:0]                  rd_data
);

   logic [2:0] mem [itp_pkg::STACK_DEPTH];
   logic [2:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/itp_seq.sv */
// itp_seq: token sequencer, walks the operator stack one entry per step
// depends on itp_pkg and drives itp_stack and the output stage
module itp_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_type,
   input  logic [2:0]                  req_operator_code,
   input  logic [31:0]                 req_operand_value,
   input  logic                        out_ready,
   output itp_pkg::emit_type           emit_out,
   output logic                        st_wr_en,
   output logic [itp_pkg::ADDR_W-1:0]  st_wr_addr,
   output logic [2:0]                  st_wr_data,
   output logic [itp_pkg::ADDR_W-1:0]  st_rd_addr,
   input  logic [2:0]                  st_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_PUSH,
      S_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 kind_ff, kind_in;
   logic [2:0]                 op_ff, op_in;
   logic [itp_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [itp_pkg::CNT_W-1:0]  paren_ff, paren_in;
   logic [itp_pkg::CNT_W-1:0]  count_m1;
   logic                       top_is_lp;
   logic                       pop_ok;
   logic [1:0]                 prec_top;
   logic [1:0]                 prec_new;

   assign count_m1   = count_ff - itp_pkg::CNT_ONE;
   assign st_rd_addr = count_m1[itp_pkg::ADDR_W-1:0];
   assign st_wr_addr = count_ff[itp_pkg::ADDR_W-1:0];
   assign req_stall  = (state_ff != S_IDLE);

   assign top_is_lp = (st_rd_data == itp_pkg::LPAREN_CODE);
   assign prec_top  = itp_pkg::prec_of(st_rd_data);
   assign prec_new  = itp_pkg::prec_of(op_ff);
   // right-associative power does not pop an equal-precedence power
   assign pop_ok    = (prec_top > prec_new) ||
                      ((prec_top == prec_new) && (op_ff != itp_pkg::OP_POW));

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      paren_in   = paren_ff;
      emit_out   = '0;
      st_wr_en   = 1'b0;
      st_wr_data = (kind_ff == itp_pkg::TOK_LPAREN) ? itp_pkg::LPAREN_CODE : op_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_type;
               op_in    = req_operator_code;
               case (req_type)
                  itp_pkg::TOK_OPERAND: begin
                     emit_out.emit           = 1'b1;
                     emit_out.result.kind    = itp_pkg::KIND_OPERAND;
                     emit_out.result.operand = req_operand_value & itp_pkg::OPERAND_MASK;
                     state_in                = S_FINISH;
                  end
                  itp_pkg::TOK_OPERATOR: begin
                     if (req_operator_code inside {[itp_pkg::OP_POW:itp_pkg::OP_SUB]}) begin
                        state_in = (count_ff != '0) ? S_READ : S_PUSH;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  itp_pkg::TOK_LPAREN: begin
                     state_in = S_PUSH;
                  end
                  itp_pkg::TOK_RPAREN: begin
                     if (paren_ff == '0) begin
                        emit_out.emit         = 1'b1;
                        emit_out.result.kind  = itp_pkg::KIND_ERROR;
                        emit_out.result.error = itp_pkg::ERR_UNMATCHED;
                        state_in              = S_FINISH;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  itp_pkg::TOK_END: begin
                     state_in = (count_ff != '0) ? S_READ : S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (out_ready) begin
               case (kind_ff)
                  itp_pkg::TOK_OPERATOR: begin
                     if (!top_is_lp && pop_ok) begin
                        emit_out.emit                 = 1'b1;
                        emit_out.result.kind          = itp_pkg::KIND_OPERATOR;
                        emit_out.result.operator_code = st_rd_data;
                        count_in                      = count_m1;
                        state_in = (count_ff != itp_pkg::CNT_ONE) ? S_READ : S_PUSH;
                     end else begin
                        state_in = S_PUSH;
                     end
                  end
                  itp_pkg::TOK_RPAREN: begin
                     count_in = count_m1;
                     if (top_is_lp) begin
                        paren_in = paren_ff - itp_pkg::CNT_ONE;
                        state_in = S_FINISH;
                     end else begin
                        emit_out.emit                 = 1'b1;
                        emit_out.result.kind          = itp_pkg::KIND_OPERATOR;
                        emit_out.result.operator_code = st_rd_data;
                        state_in                      = S_READ;
                     end
                  end
                  default: begin
                     // end token: flush, dropping open parens
                     count_in = count_m1;
                     if (top_is_lp) begin
                        paren_in = paren_ff - itp_pkg::CNT_ONE;
                     end else begin
                        emit_out.emit                 = 1'b1;
                        emit_out.result.kind          = itp_pkg::KIND_OPERATOR;
                        emit_out.result.operator_code = st_rd_data;
                     end
                     state_in = (count_ff != itp_pkg::CNT_ONE) ? S_READ : S_FINISH;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (out_ready) begin
               if (count_ff >= itp_pkg::CNT_FULL) begin
                  emit_out.emit         = 1'b1;
                  emit_out.result.kind  = itp_pkg::KIND_ERROR;
                  emit_out.result.error = itp_pkg::ERR_OVERFLOW;
               end else begin
                  st_wr_en = 1'b1;
                  count_in = count_ff + itp_pkg::CNT_ONE;
                  if (kind_ff == itp_pkg::TOK_LPAREN) begin
                     paren_in = paren_ff + itp_pkg::CNT_ONE;
                  end
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            emit_out.close = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         paren_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         paren_ff <= paren_in;
      end
      kind_ff  <= kind_in;
      op_ff    <= op_in;
   end

endmodule

/* design/itp_out.sv */
// itp_out: result hold stage and output register, marks the last beat of a token
// depends on itp_pkg for the result and emit structs
module itp_out (
   input  logic              clock,
   input  logic              reset,
   input  itp_pkg::emit_type emit_in,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_out_kind,
   output logic [31:0]       rsp_out_operand,
   output logic [2:0]        rsp_out_operator,
   output logic [1:0]        rsp_error_code,
   output logic              rsp_last_of_run
);

   logic                 hold_valid_ff, hold_valid_in;
   itp_pkg::result_type  hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   itp_pkg::result_type  rsp_ff, rsp_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_ready = !hold_valid_ff || out_free;
   // held result moves out when a newer one arrives or the token closes
   assign load      = out_ready && hold_valid_ff && (emit_in.emit || emit_in.close);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_in        = rsp_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_in       = hold_ff;
         last_in      = emit_in.close && !emit_in.emit;
         rsp_valid_in = 1'b1;
      end
      if (out_ready && emit_in.emit) begin
         hold_in       = emit_in.result;
         hold_valid_in = 1'b1;
      end else if (out_ready && emit_in.close) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_ff.kind;
   assign rsp_out_operand  = rsp_ff.operand;
   assign rsp_out_operator = rsp_ff.operator_code;
   assign rsp_error_code   = rsp_ff.error;
   assign rsp_last_of_run  = last_ff;

endmodule

/* design/infix_to_postfix_converter_unit.sv */
// infix_to_postfix_converter_unit: top level of the shunting-yard converter
// depends on itp_pkg, itp_stack, itp_seq and itp_out
//
//   channel  direction  handshake            beat contents
//   req      in         req_valid/req_stall  token kind, operator code, operand value
//   rsp      out        rsp_valid/rsp_stall  result kind, operand, operator, error, last
//
// one token at a time; req_stall is high from accept until its last beat is handed on
// operand or ')' error: emitted at accept, then close-out; each stack entry read (popped, dropped or
// ending a scan): registered stack read, then compare; compare, push and close-out each wait on out_ready
// the stack memory's single registered read port sets the per-entry pace
// reset clears the stack count, paren count and all valid flags; stack needs no clearing
// rsp_stall holds the sequencer once the hold stage and output register are both full
module infix_to_postfix_converter_unit (
   input  logic        clock,
   input  logic        reset,
   // token input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_operator_code,
   input  logic [31:0] req_operand_value,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_out_operand,
   output logic [2:0]  rsp_out_operator,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   // sequencer <-> output stage
   itp_pkg::emit_type             emit_bus;
   logic                          out_ready;

   // sequencer <-> stack memory
   logic                          st_wr_en;
   logic [itp_pkg::ADDR_W-1:0]    st_wr_addr;
   logic [2:0]                    st_wr_data;
   logic [itp_pkg::ADDR_W-1:0]    st_rd_addr;
   logic [2:0]                    st_rd_data;

   // operator stack: entries above the count are never used
   itp_stack u_stack (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // token sequencer: pops one entry per read/compare pair; operators and '(' are then pushed
   itp_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_operator_code (req_operator_code),
      .req_operand_value (req_operand_value),
      .out_ready         (out_ready),
      .emit_out          (emit_bus),
      .st_wr_en          (st_wr_en),
      .st_wr_addr        (st_wr_addr),
      .st_wr_data        (st_wr_data),
      .st_rd_addr        (st_rd_addr),
      .st_rd_data        (st_rd_data)
   );

   // one-deep hold lets the last beat of a token be flagged when the token closes
   itp_out u_out (
      .clock            (clock),
      .reset            (reset),
      .emit_in          (emit_bus),
      .out_ready        (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_operand  (rsp_out_operand),
      .rsp_out_operator (rsp_out_operator),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

/* test/tb_infix_to_postfix_converter_unit.sv */
// tb_infix_to_postfix_converter_unit: checks the shunting-yard converter against a
// built-in stack predictor, directed rows first, then random expressions and noise
// depends on itp_pkg and infix_to_postfix_converter_unit
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter_unit;

   // out-of-range codes the block must ignore
   localparam logic [2:0] TOK_ALL_ONES = 3'd7;
   localparam logic [2:0] OP_ALL_ONES  = 3'd7;
   // operator field of a beat that carries no operator
   localparam logic [2:0] NO_OP        = 3'd0;

   localparam int RANDOM_TOKENS = 250;
   localparam int STEADY_TOKENS = 70;
   localparam int IDLE_PCT      = 37;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  opc;
      logic [31:0] value;
   } token_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] operand;
      logic [2:0]  opc;
      logic [1:0]  err;
      logic        last;
   } beat_type;

   // one row of the directed table; pinned rows carry a hand-written result
   typedef struct {
      int        reps;
      token_type tok;
      bit        pinned;
      beat_type  want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = itp_pkg::TOK_END;
   logic [2:0]  req_operator_code = NO_OP;
   logic [31:0] req_operand_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [31:0] rsp_out_operand;
   logic [2:0]  rsp_out_operator;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_of_run;

   // predictor state: operator stack with '(' markers
   logic [2:0]  op_stack [itp_pkg::STACK_DEPTH];
   int          stack_depth = 0;

   beat_type    step_q[$];     // beats caused by the token being converted
   beat_type    postfix_q[$];  // beats still owed by the block, oldest first
   row_type     plan_q[$];

   bit          steady = 1'b1; // no idling on either side while set
   int          fail_count = 0;
   int          tokens_sent = 0;
   int          useful_sent = 0;
   int          beats_seen = 0;
   int          overflow_seen = 0;
   int          unmatched_seen = 0;
   int          max_run = 0;

   infix_to_postfix_converter_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_operator_code (req_operator_code),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_operand   (rsp_out_operand),
      .rsp_out_operator  (rsp_out_operator),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // binding strength: power binds tightest, then mul/div, then add/sub
   function automatic int op_rank(input logic [2:0] op);
      if (op == itp_pkg::OP_POW) begin
         return 3;
      end else if (op == itp_pkg::OP_MUL || op == itp_pkg::OP_DIV) begin
         return 2;
      end
      return 1;
   endfunction

   function automatic void emit_beat(input logic [1:0] kind, input logic [31:0] operand,
                                     input logic [2:0] opc, input logic [1:0] err);
      beat_type b;
      b.kind    = kind;
      b.operand = operand;
      b.opc     = opc;
      b.err     = err;
      b.last    = 1'b0;
      step_q.push_back(b);
   endfunction

   function automatic void pop_to_output();
      stack_depth = stack_depth - 1;
      emit_beat(itp_pkg::KIND_OPERATOR, 32'd0, op_stack[stack_depth], itp_pkg::ERR_NONE);
   endfunction

   // a push onto a full stack turns into an overflow beat and the token is dropped
   function automatic void push_entry(input logic [2:0] code);
      if (stack_depth >= itp_pkg::STACK_DEPTH) begin
         emit_beat(itp_pkg::KIND_ERROR, 32'd0, NO_OP, itp_pkg::ERR_OVERFLOW);
      end else begin
         op_stack[stack_depth] = code;
         stack_depth = stack_depth + 1;
      end
   endfunction

   // fills step_q with the postfix beats one infix token produces
   function automatic void convert_token(input token_type t);
      logic [2:0] top;
      bit         done;
      bit         found;
      step_q.delete();
      case (t.kind)
         itp_pkg::TOK_OPERAND: begin
            emit_beat(itp_pkg::KIND_OPERAND, t.value & itp_pkg::OPERAND_MASK, NO_OP,
                      itp_pkg::ERR_NONE);
         end
         itp_pkg::TOK_OPERATOR: begin
            if (t.opc <= itp_pkg::OP_SUB) begin
               done = 1'b0;
               while (stack_depth > 0 && !done) begin
                  top = op_stack[stack_depth - 1];
                  if (top == itp_pkg::LPAREN_CODE) begin
                     done = 1'b1;
                  end else if (op_rank(top) > op_rank(t.opc) ||
                               (op_rank(top) == op_rank(t.opc) &&
                                t.opc != itp_pkg::OP_POW)) begin
                     pop_to_output();
                  end else begin
                     done = 1'b1;
                  end
               end
               push_entry(t.opc);
            end
         end
         itp_pkg::TOK_LPAREN: begin
            push_entry(itp_pkg::LPAREN_CODE);
         end
         itp_pkg::TOK_RPAREN: begin
            found = 1'b0;
            for (int i = 0; i < stack_depth; i++) begin
               if (op_stack[i] == itp_pkg::LPAREN_CODE) found = 1'b1;
            end
            if (!found) begin
               emit_beat(itp_pkg::KIND_ERROR, 32'd0, NO_OP, itp_pkg::ERR_UNMATCHED);
            end else begin
               while (op_stack[stack_depth - 1] != itp_pkg::LPAREN_CODE) pop_to_output();
               stack_depth = stack_depth - 1;
            end
         end
         itp_pkg::TOK_END: begin
            // flush, silently dropping any open paren
            while (stack_depth > 0) begin
               if (op_stack[stack_depth - 1] == itp_pkg::LPAREN_CODE) begin
                  stack_depth = stack_depth - 1;
               end else begin
                  pop_to_output();
               end
            end
         end
         default: begin
         end
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      if (step_q.size() > max_run) max_run = step_q.size();
   endfunction

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------

   // drives one token at the falling edge, holds it until accepted, then predicts
   task automatic send_token(input token_type t, input bit pinned, input beat_type want);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= t.kind;
      req_operator_code <= t.opc;
      req_operand_value <= t.value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // beat accepted at this edge
      tokens_sent++;
      if (t.kind <= itp_pkg::TOK_END &&
          !(t.kind == itp_pkg::TOK_OPERATOR && t.opc > itp_pkg::OP_SUB)) useful_sent++;
      convert_token(t);
      if (pinned) begin
         postfix_q.push_back(want);
      end else begin
         foreach (step_q[i]) postfix_q.push_back(step_q[i]);
      end
   endtask

   task automatic feed(input logic [2:0] kind, input logic [2:0] opc,
                       input logic [31:0] value);
      token_type t;
      t.kind  = kind;
      t.opc   = opc;
      t.value = value;
      send_token(t, 1'b0, '0);
   endtask

   // sender holds off until every owed beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (postfix_q.size() > 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_row(input int reps, input logic [2:0] kind,
                                   input logic [2:0] opc, input logic [31:0] value);
      row_type r;
      r.reps      = reps;
      r.tok.kind  = kind;
      r.tok.opc   = opc;
      r.tok.value = value;
      r.pinned    = 1'b0;
      r.want      = '0;
      plan_q.push_back(r);
   endfunction

   function automatic void add_pinned(input logic [2:0] kind, input logic [2:0] opc,
                                      input logic [31:0] value, input logic [1:0] wkind,
                                      input logic [31:0] woperand, input logic [2:0] wop,
                                      input logic [1:0] werr);
      row_type r;
      r.reps         = 1;
      r.tok.kind     = kind;
      r.tok.opc      = opc;
      r.tok.value    = value;
      r.pinned       = 1'b1;
      r.want.kind    = wkind;
      r.want.operand = woperand;
      r.want.opc     = wop;
      r.want.err     = werr;
      r.want.last    = 1'b1;
      plan_q.push_back(r);
   endfunction

   // one random infix expression: mostly well formed, sometimes nested past the
   // stack depth, sometimes a long power chain, with stray tokens mixed in
   task automatic send_expression();
      int open_n;
      int terms;
      int flavor;
      open_n = 0;
      flavor = $urandom_range(7);
      if (flavor == 0) begin
         // deep nesting, may run into the overflow path
         repeat ($urandom_range(18, 12)) begin
            feed(itp_pkg::TOK_LPAREN, NO_OP, 32'd0);
            open_n++;
         end
      end
      feed(itp_pkg::TOK_OPERAND, NO_OP, rand_operand());
      if (flavor == 1) begin
         // right-assoc chain stacks up, the next lower operator pops it all
         repeat ($urandom_range(17, 10)) begin
            feed(itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0);
            feed(itp_pkg::TOK_OPERAND, NO_OP, rand_operand());
         end
      end
      terms = $urandom_range(8, 1);
      repeat (terms) begin
         if ($urandom_range(11) == 0) begin
            // stray token of any kind, valid or not
            feed(3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
         end
         feed(itp_pkg::TOK_OPERATOR, 3'($urandom_range(4)), $urandom);
         while ($urandom_range(3) == 0) begin
            feed(itp_pkg::TOK_LPAREN, NO_OP, 32'd0);
            open_n++;
         end
         feed(itp_pkg::TOK_OPERAND, 3'($urandom_range(7)), rand_operand());
         while (open_n > 0 && $urandom_range(2) == 0) begin
            feed(itp_pkg::TOK_RPAREN, NO_OP, 32'd0);
            open_n--;
         end
      end
      if ($urandom_range(1) == 0) begin
         while (open_n > 0) begin
            feed(itp_pkg::TOK_RPAREN, NO_OP, 32'd0);
            open_n--;
         end
      end
      // now and then leave the expression open so the next one piles on
      if ($urandom_range(5) != 0) feed(itp_pkg::TOK_END, NO_OP, 32'd0);
   endtask

   // ------------------------------------------------------------------
   // output side
   // ------------------------------------------------------------------

   // result side stalls at random except during steady stretches
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // every accepted result beat is matched against the oldest owed beat
   always @(posedge clock) begin : rsp_check
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (rsp_out_kind == itp_pkg::KIND_ERROR &&
             rsp_error_code == itp_pkg::ERR_OVERFLOW) overflow_seen++;
         if (rsp_out_kind == itp_pkg::KIND_ERROR &&
             rsp_error_code == itp_pkg::ERR_UNMATCHED) unmatched_seen++;
         if (postfix_q.size() == 0) begin
            $display({"%0t: unexpected beat, expected none, ",
                      "actual kind %0h operand %0h op %0h err %0h"},
                     $time, rsp_out_kind, rsp_out_operand, rsp_out_operator, rsp_error_code);
            fail_count++;
         end else begin
            want = postfix_q.pop_front();
            check_field("kind",     32'(want.kind),    32'(rsp_out_kind));
            check_field("operand",  want.operand,      rsp_out_operand);
            check_field("operator", 32'(want.opc),     32'(rsp_out_operator));
            check_field("error",    32'(want.err),     32'(rsp_error_code));
            check_field("last",     32'(want.last),    32'(rsp_last_of_run));
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      int  base;
      bit  mid_pause;

      // operand extremes straight after reset
      add_pinned(itp_pkg::TOK_OPERAND, NO_OP, 32'd0,
                 itp_pkg::KIND_OPERAND, 32'd0, NO_OP, itp_pkg::ERR_NONE);
      add_pinned(itp_pkg::TOK_OPERAND, OP_ALL_ONES, 32'hFFFF_FFFF,
                 itp_pkg::KIND_OPERAND, 32'hFFFF_FFFF, NO_OP, itp_pkg::ERR_NONE);
      // close paren on an empty stack
      add_pinned(itp_pkg::TOK_RPAREN, NO_OP, 32'd0,
                 itp_pkg::KIND_ERROR, 32'd0, NO_OP, itp_pkg::ERR_UNMATCHED);
      // unknown token kind and unknown operator code are dropped silently
      add_row(1, TOK_ALL_ONES, OP_ALL_ONES, 32'hFFFF_FFFF);
      add_row(1, itp_pkg::TOK_OPERATOR, OP_ALL_ONES, 32'd0);
      // end with nothing stacked
      add_row(1, itp_pkg::TOK_END, NO_OP, 32'd0);
      // fill the stack to the brim without a single pop: each op binds tighter
      // than the one below it, '(' starts a fresh climb, power stacks on power
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_ADD, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_MUL, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0);
      add_row(1, itp_pkg::TOK_LPAREN,   NO_OP,           32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_SUB, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_DIV, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0);
      add_row(1, itp_pkg::TOK_LPAREN,   NO_OP,           32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_ADD, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_MUL, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0);
      add_row(1, itp_pkg::TOK_LPAREN,   NO_OP,           32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_SUB, 32'd0);
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_DIV, 32'd0);
      add_row(2, itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0);
      // stack full: another power pops nothing and overflows
      add_pinned(itp_pkg::TOK_OPERATOR, itp_pkg::OP_POW, 32'd0,
                 itp_pkg::KIND_ERROR, 32'd0, NO_OP, itp_pkg::ERR_OVERFLOW);
      // subtract pops down to the open paren, equal rank included
      add_row(1, itp_pkg::TOK_OPERATOR, itp_pkg::OP_SUB, 32'd0);
      add_row(1, itp_pkg::TOK_RPAREN,   NO_OP,           32'd0);
      add_row(1, itp_pkg::TOK_END,      NO_OP,           32'd0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         repeat (plan_q[i].reps) send_token(plan_q[i].tok, plan_q[i].pinned, plan_q[i].want);
      end
      drain();

      // random part: opens with a stretch free of idling, then idles both sides
      base      = useful_sent;
      mid_pause = 1'b0;
      while (useful_sent - base < RANDOM_TOKENS) begin
         if (useful_sent - base >= STEADY_TOKENS) steady = 1'b0;
         if (!mid_pause && useful_sent - base >= RANDOM_TOKENS / 2) begin
            drain();
            mid_pause = 1'b1;
         end
         send_expression();
      end

      drain();
      // room for any stray beat to show up
      repeat (64) @(posedge clock);

      $display("tb: %0d tokens sent, %0d result beats checked, longest run %0d",
               tokens_sent, beats_seen, max_run);
      $display("tb: %0d overflow and %0d unmatched-paren errors seen",
               overflow_seen, unmatched_seen);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
